// File: rtl/gds_pkg.sv
package gds_pkg;

  localparam int DEF_COUNT_BITS = 16;
  localparam int DEF_YEAR_BITS  = 14;
  localparam int QUEUE_DEPTH    = 2;

  localparam int DAY_BITS   = 5;
  localparam int MONTH_BITS = 4;
  localparam int FUNC_BITS  = 2;
  localparam int STAT_BITS  = 2;
  localparam int RES_BITS   = 5;

  localparam logic [RES_BITS-1:0]   RES_MOD  = 5'd25;
  localparam logic [RES_BITS-1:0]   RES_LAST = 5'd24;
  localparam logic [MONTH_BITS-1:0] MON_JAN  = 4'd1;
  localparam logic [MONTH_BITS-1:0] MON_DEC  = 4'd12;

  // floor(y / 25) == (y * RES_RECIP) >> RES_SHIFT for any 32-bit y
  localparam logic [31:0] RES_RECIP = 32'h51EB851F;
  localparam int          RES_SHIFT = 35;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_NEXT = 2'd0,
    FUNC_PREV = 2'd1,
    FUNC_ADD  = 2'd2,
    FUNC_SUB  = 2'd3
  } func_t;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_DATE = 2'd1,
    STAT_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    logic fwd;
    logic bad;
  } entry_flags_t;

  function automatic int entry_bits(input int count_bits, input int year_bits);
    entry_bits = count_bits + RES_BITS + year_bits + MONTH_BITS + DAY_BITS
                 + $bits(entry_flags_t);
  endfunction

  // year mod 400 == 0 is year mod 16 == 0 and year mod 25 == 0
  function automatic logic is_leap(input logic [3:0] year_low, input logic res_zero);
    is_leap = (year_low[1:0] == 2'd0 && !res_zero) || (year_low == 4'd0 && res_zero);
  endfunction

  function automatic logic [DAY_BITS-1:0] month_days(input logic [MONTH_BITS-1:0] m,
                                                     input logic leap);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    month_days = 5'd30;
      default:                                    month_days = leap ? 5'd29 : 5'd28;
    endcase
  endfunction

  function automatic logic [RES_BITS-1:0] res_inc(input logic [RES_BITS-1:0] r);
    res_inc = (r == RES_LAST) ? '0 : r + 1'b1;
  endfunction

  function automatic logic [RES_BITS-1:0] res_dec(input logic [RES_BITS-1:0] r);
    res_dec = (r == '0) ? RES_LAST : r - 1'b1;
  endfunction

endpackage

// File: rtl/gds_queue.sv
module gds_queue
  import gds_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] cnt;
  logic             wr;
  logic             rd;

  assign wr_ready = (cnt != CNT_W'(DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rptr];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr) begin
        mem[wptr] <= wr_data;
        wptr      <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        cnt <= cnt + 1'b1;
      end else if (rd && !wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH)) else $error("queue count beyond depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> cnt == $past(cnt) + 1'b1) else $error("queue count lost a write");

endmodule

// File: rtl/gds_front.sv
module gds_front
  import gds_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int YEAR_BITS  = DEF_YEAR_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [FUNC_BITS-1:0]                          in_func,
  input  logic [DAY_BITS-1:0]                           in_day,
  input  logic [MONTH_BITS-1:0]                         in_month,
  input  logic [YEAR_BITS-1:0]                          in_year,
  input  logic [COUNT_BITS-1:0]                         in_count,
  output logic                                          q_valid,
  input  logic                                          q_ready,
  output logic [entry_bits(COUNT_BITS, YEAR_BITS)-1:0]  q_data
);

  localparam int QUOT_W = 64 - RES_SHIFT;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_QUOT = 4'b0010,
    F_MOD  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t            state;
  func_t                   func_r;
  logic [DAY_BITS-1:0]     day_r;
  logic [MONTH_BITS-1:0]   mon_r;
  logic [YEAR_BITS-1:0]    year_r;
  logic [COUNT_BITS-1:0]   cnt_r;
  logic [31:0]             year_w;
  logic [63:0]             prod;
  logic [QUOT_W-1:0]       quot;
  logic [31:0]             quot25;
  logic [RES_BITS-1:0]     res;
  logic                    leap;
  logic [COUNT_BITS-1:0]   step_cnt;
  entry_flags_t            flags;

  assign in_ready = (state == F_IDLE);
  assign q_valid  = (state == F_PUSH);

  assign year_w    = 32'(year_r);
  assign prod      = 64'(year_w) * 64'(RES_RECIP);
  assign quot25    = 32'(quot) * 32'd25;

  assign leap      = is_leap(year_r[3:0], res == '0);
  assign flags.fwd = (func_r == FUNC_NEXT) || (func_r == FUNC_ADD);
  assign flags.bad = (mon_r < MON_JAN) || (mon_r > MON_DEC) || (day_r == '0)
                     || (day_r > month_days(mon_r, leap));
  assign step_cnt  = (func_r == FUNC_NEXT || func_r == FUNC_PREV) ? COUNT_BITS'(1) : cnt_r;
  assign q_data    = {step_cnt, res, year_r, mon_r, day_r, flags};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) state <= F_QUOT;
        end
        F_QUOT: begin
          state <= F_MOD;
        end
        F_MOD: begin
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (q_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // year mod 25: reciprocal multiply for the quotient, then subtract
  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      func_r <= func_t'(in_func);
      day_r  <= in_day;
      mon_r  <= in_month;
      year_r <= in_year;
      cnt_r  <= in_count;
    end else if (state == F_QUOT) begin
      quot <= prod[63:RES_SHIFT];
    end else if (state == F_MOD) begin
      res <= RES_BITS'(year_w - quot25);
    end
  end

  a_res_range: assert property (@(posedge clk) disable iff (rst)
    state == F_PUSH |-> res < RES_MOD) else $error("year residue out of range");

endmodule

// File: rtl/gds_walk.sv
module gds_walk
  import gds_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int YEAR_BITS  = DEF_YEAR_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          q_valid,
  output logic                                          q_ready,
  input  logic [entry_bits(COUNT_BITS, YEAR_BITS)-1:0]  q_data,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [DAY_BITS-1:0]                           out_day,
  output logic [MONTH_BITS-1:0]                         out_month,
  output logic [YEAR_BITS-1:0]                          out_year,
  output status_t                                       out_status
);

  localparam int AW = ((COUNT_BITS > DAY_BITS) ? COUNT_BITS : DAY_BITS) + 1;

  typedef enum logic [4:0] {
    W_IDLE  = 5'b00001,
    W_START = 5'b00010,
    W_FWD   = 5'b00100,
    W_BWD   = 5'b01000,
    W_DONE  = 5'b10000
  } walk_state_t;

  walk_state_t             state;
  logic [COUNT_BITS-1:0]   e_count;
  logic [RES_BITS-1:0]     e_res;
  logic [YEAR_BITS-1:0]    e_year;
  logic [MONTH_BITS-1:0]   e_mon;
  logic [DAY_BITS-1:0]     e_day;
  entry_flags_t            e_flags;

  logic                    fwd;
  logic [AW-1:0]           acc;
  logic [AW-1:0]           kreg;
  logic [MONTH_BITS-1:0]   mon;
  logic [YEAR_BITS-1:0]    year;
  logic [RES_BITS-1:0]     res;
  status_t                 stat;

  logic [AW-1:0]           md;
  logic                    fwd_fail;
  logic [MONTH_BITS-1:0]   mon_up;
  logic [YEAR_BITS-1:0]    year_up;
  logic [RES_BITS-1:0]     res_up;
  logic                    back_fail;
  logic [MONTH_BITS-1:0]   mon_dn;
  logic [YEAR_BITS-1:0]    year_dn;
  logic [RES_BITS-1:0]     res_dn;
  logic                    out_load;

  assign {e_count, e_res, e_year, e_mon, e_day, e_flags} = q_data;

  assign q_ready  = (state == W_IDLE);
  assign out_load = (state == W_DONE) && (!out_valid || out_ready);

  assign md = AW'(month_days(mon, is_leap(year[3:0], res == '0)));

  assign fwd_fail = (mon == MON_DEC) && (year == '1);
  assign mon_up   = (mon == MON_DEC) ? MON_JAN : mon + 1'b1;
  assign year_up  = (mon == MON_DEC) ? year + 1'b1 : year;
  assign res_up   = (mon == MON_DEC) ? res_inc(res) : res;

  assign back_fail = (mon == MON_JAN) && (year == '0);
  assign mon_dn    = (mon == MON_JAN) ? MON_DEC : mon - 1'b1;
  assign year_dn   = (mon == MON_JAN) ? year - 1'b1 : year;
  assign res_dn    = (mon == MON_JAN) ? res_dec(res) : res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= W_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        W_IDLE: begin
          if (q_valid) begin
            fwd   <= e_flags.fwd;
            acc   <= AW'(e_day);
            kreg  <= AW'(e_count);
            mon   <= e_mon;
            year  <= e_year;
            res   <= e_res;
            stat  <= e_flags.bad ? STAT_BAD_DATE : STAT_OK;
            state <= e_flags.bad ? W_DONE : W_START;
          end
        end
        W_START: begin
          if (fwd) begin
            acc   <= acc + kreg;
            state <= W_FWD;
          end else if (acc > kreg) begin
            acc   <= acc - kreg;
            state <= W_DONE;
          end else if (back_fail) begin
            stat  <= STAT_RANGE;
            state <= W_DONE;
          end else begin
            acc   <= kreg - acc;
            mon   <= mon_dn;
            year  <= year_dn;
            res   <= res_dn;
            state <= W_BWD;
          end
        end
        W_FWD: begin
          if (acc > md) begin
            acc <= acc - md;
            if (fwd_fail) begin
              stat  <= STAT_RANGE;
              state <= W_DONE;
            end else begin
              mon  <= mon_up;
              year <= year_up;
              res  <= res_up;
            end
          end else begin
            state <= W_DONE;
          end
        end
        W_BWD: begin
          if (acc >= md) begin
            acc <= acc - md;
            if (back_fail) begin
              stat  <= STAT_RANGE;
              state <= W_DONE;
            end else begin
              mon  <= mon_dn;
              year <= year_dn;
              res  <= res_dn;
            end
          end else begin
            acc   <= md - acc;
            state <= W_DONE;
          end
        end
        W_DONE: begin
          if (out_load) state <= W_IDLE;
        end
        default: state <= W_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (stat == STAT_OK) begin
        out_day   <= acc[DAY_BITS-1:0];
        out_month <= mon;
        out_year  <= year;
      end else begin
        out_day   <= '0;
        out_month <= '0;
        out_year  <= '0;
      end
      out_status <= stat;
    end
  end

  a_month_live: assert property (@(posedge clk) disable iff (rst)
    (state == W_FWD || state == W_BWD) |-> (mon >= MON_JAN && mon <= MON_DEC))
    else $error("month left 1..12 during walk");

  a_day_final: assert property (@(posedge clk) disable iff (rst)
    (state == W_DONE && stat == STAT_OK) |-> (acc != '0 && acc <= AW'(31)))
    else $error("final day out of range");

  a_res_live: assert property (@(posedge clk) disable iff (rst)
    (state == W_FWD || state == W_BWD) |-> res < RES_MOD)
    else $error("year residue out of range during walk");

endmodule

// File: rtl/gregorian_date_stepper_top.sv
// Gregorian date stepper: each request carries a date, an operation in tuser (next day,
// previous day, add or subtract the count) and a day count, and yields one result
// with a status in tuser (ok, invalid input date, result year out of range; the date
// reads zero unless ok). The front takes a request, finds the year modulo 25 for the
// leap rule by a reciprocal multiply (quotient register, then residue register) and
// checks the date; a two-entry queue hands it to the back, which walks one month per
// cycle. The back's time per item grows with the months crossed (a count of 65535 days
// crosses about 2153 months), and the front and back overlap, so that month walk sets
// the rate. Results wait in an output register while the next request is taken.
module gregorian_date_stepper_top
  import gds_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int YEAR_BITS  = DEF_YEAR_BITS
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   s_axis_tvalid,
  output logic                                                   s_axis_tready,
  // in_day, in_month, in_year, day_count
  input  logic [((DAY_BITS+MONTH_BITS+YEAR_BITS+COUNT_BITS+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  logic [FUNC_BITS-1:0]                                   s_axis_tuser,
  output logic                                                   m_axis_tvalid,
  input  logic                                                   m_axis_tready,
  // out_day, out_month, out_year
  output logic [((DAY_BITS+MONTH_BITS+YEAR_BITS+7)/8)*8-1:0]     m_axis_tdata,
  // status
  output logic [STAT_BITS-1:0]                                   m_axis_tuser
);

  localparam int OUT_W   = ((DAY_BITS + MONTH_BITS + YEAR_BITS + 7) / 8) * 8;
  localparam int ENTRY_W = entry_bits(COUNT_BITS, YEAR_BITS);
  localparam int MON_LO  = DAY_BITS;
  localparam int YEAR_LO = MON_LO + MONTH_BITS;
  localparam int CNT_LO  = YEAR_LO + YEAR_BITS;

  logic                  qw_valid;
  logic                  qw_ready;
  logic [ENTRY_W-1:0]    qw_data;
  logic                  qr_valid;
  logic                  qr_ready;
  logic [ENTRY_W-1:0]    qr_data;
  logic [DAY_BITS-1:0]   out_day;
  logic [MONTH_BITS-1:0] out_month;
  logic [YEAR_BITS-1:0]  out_year;
  status_t               out_status;

  gds_front #(
    .COUNT_BITS (COUNT_BITS),
    .YEAR_BITS  (YEAR_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_func  (s_axis_tuser),
    .in_day   (s_axis_tdata[DAY_BITS-1:0]),
    .in_month (s_axis_tdata[YEAR_LO-1:MON_LO]),
    .in_year  (s_axis_tdata[CNT_LO-1:YEAR_LO]),
    .in_count (s_axis_tdata[CNT_LO+COUNT_BITS-1:CNT_LO]),
    .q_valid  (qw_valid),
    .q_ready  (qw_ready),
    .q_data   (qw_data)
  );

  gds_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (qw_valid),
    .wr_ready (qw_ready),
    .wr_data  (qw_data),
    .rd_valid (qr_valid),
    .rd_ready (qr_ready),
    .rd_data  (qr_data)
  );

  gds_walk #(
    .COUNT_BITS (COUNT_BITS),
    .YEAR_BITS  (YEAR_BITS)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (qr_valid),
    .q_ready    (qr_ready),
    .q_data     (qr_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_day    (out_day),
    .out_month  (out_month),
    .out_year   (out_year),
    .out_status (out_status)
  );

  assign m_axis_tdata = OUT_W'({out_year, out_month, out_day});
  assign m_axis_tuser = out_status;

endmodule
